@@ sv/lru_key_value_cache_defines.svh @@
// Assertion macros used by the checker file of the LRU key-value cache.
// Needs nothing else; include by bare file name.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication; pass 1'b0 as rst to keep it armed through reset.
`define LRUKV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru cache check failed");

// Next-cycle implication.
`define LRUKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru cache check failed");

`endif

@@ sv/lrukv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the LRU key-value cache.
// No dependencies; imported by every module of the block.
package lrukv_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_TOUCH  = 2'd1;
   localparam logic [1:0] ACT_INSERT = 2'd2;

   typedef struct packed {
      logic                    op;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
      logic                    evicted;
      logic signed [KEY_W-1:0] evicted_key;
   } rsp_payload_type;

   // Broadcast from the control path to every entry.
   typedef struct packed {
      logic [1:0]              action;
      logic                    write_value;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } entry_cmd_type;

   // What one entry shows back to the control path.
   typedef struct packed {
      logic                    valid;
      logic                    match;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } entry_status_type;

endpackage

@@ sv/lrukv_entry.sv @@
`timescale 1ns / 1ps
// One cache entry: key, value, valid bit and recency rank, with its own key compare.
// Depends on lrukv_pkg.
module lrukv_entry #(
   parameter int RANK_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lrukv_pkg::entry_cmd_type     cmd,
   input  logic                         sel,
   input  logic [RANK_W-1:0]            touch_rank,
   output lrukv_pkg::entry_status_type  status,
   output logic [RANK_W-1:0]            rank
);
   import lrukv_pkg::*;

   logic                    valid_ff, valid_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [RANK_W-1:0]       rank_ff, rank_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      unique case (cmd.action)
         ACT_TOUCH: begin
            if (sel) begin
               rank_in = '0;
               if (cmd.write_value) begin
                  value_in = cmd.value;
               end
            end else if (valid_ff && (rank_ff < touch_rank)) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
         ACT_INSERT: begin
            // the selected slot may be the victim; it is simply overwritten
            if (sel) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               value_in = cmd.value;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign status.valid = valid_ff;
   assign status.match = valid_ff && (key_ff == cmd.key);
   assign status.key   = key_ff;
   assign status.value = value_ff;
   assign rank         = rank_ff;

endmodule

@@ sv/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// Top level of the fully associative LRU key-value cache.
// Depends on lrukv_pkg and lrukv_entry.
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+----------------------------
//   request | req_valid, req_stall, req_payload      | get/put with key and value
//   result  | rsp_valid, rsp_stall, rsp_payload      | hit, value, eviction report
//   config  | csr_write_enable, csr_write_data       | capacity register
//
// One transfer per cycle sustained while rsp_stall is low; a request passes the input register,
// then one pass of parallel key compare and rank update over all entries into the result
// register, which is also when the entries are written.
// Reset clears valid bits, ranks and occupancy at once and sets capacity to 16.
// A held result stalls the input register; req_stall rises once that register is also full.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lrukv_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lrukv_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [lrukv_pkg::CAP_W-1:0] csr_write_data
);
   import lrukv_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic              req_valid_ff, req_valid_in;
   req_payload_type   req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;

   entry_cmd_type     cmd;
   entry_status_type  status [ENTRIES];
   logic [RANK_W-1:0] rank [ENTRIES];
   logic [ENTRIES-1:0] hit_vec, valid_vec, free_vec, victim_vec, sel_vec;
   logic [RANK_W-1:0] touch_rank, oldest_rank;
   logic [OCC_W-1:0]  occ_less_one;
   logic [CMP_W-1:0]  cap_ext, eff_cap;
   logic              advance, hit, use_free, is_put;
   logic signed [VAL_W-1:0] hit_value;
   logic signed [KEY_W-1:0] victim_key;

   // pipeline handshake
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign req_valid_in = (req_valid && !req_stall) || (req_valid_ff && !advance);
   assign req_in       = (req_valid && !req_stall) ? req_payload : req_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   // effective capacity clamped to 1..ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // gather per-entry status
   always_comb begin
      touch_rank = '0;
      hit_value  = '0;
      victim_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = status[i].match;
         valid_vec[i]  = status[i].valid;
         victim_vec[i] = status[i].valid && (rank[i] == oldest_rank);
         touch_rank    = touch_rank | (rank[i] & {RANK_W{status[i].match}});
         hit_value     = hit_value | (status[i].value & {VAL_W{status[i].match}});
         victim_key    = victim_key | (status[i].key & {KEY_W{victim_vec[i]}});
      end
   end

   // ranks of valid entries are a permutation of 0..occ-1, so the oldest holds occ-1
   assign occ_less_one = occ_ff - OCC_W'(1);
   assign oldest_rank  = occ_less_one[RANK_W-1:0];
   assign free_vec     = ~valid_vec & (valid_vec + ENTRIES'(1));
   assign hit          = |hit_vec;
   assign is_put       = (req_ff.op == OP_PUT);
   assign use_free     = CMP_W'(occ_ff) < eff_cap;

   always_comb begin
      priority if (hit) begin
         sel_vec = hit_vec;
      end else if (use_free) begin
         sel_vec = free_vec;
      end else begin
         sel_vec = victim_vec;
      end
   end

   always_comb begin
      cmd.key         = req_ff.key;
      cmd.value       = req_ff.value;
      cmd.write_value = is_put;
      cmd.action      = ACT_NONE;
      if (advance) begin
         if (hit) begin
            cmd.action = ACT_TOUCH;
         end else if (is_put) begin
            cmd.action = ACT_INSERT;
         end
      end
   end

   assign occ_in = (advance && !hit && is_put && use_free) ? occ_ff + OCC_W'(1) : occ_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_in.hit         = hit;
         rsp_in.evicted     = 1'b0;
         rsp_in.evicted_key = '0;
         if (!is_put) begin
            rsp_in.read_value = hit ? hit_value : '1;
         end else begin
            rsp_in.read_value = '0;
            if (!hit && !use_free) begin
               rsp_in.evicted     = 1'b1;
               rsp_in.evicted_key = victim_key;
            end
         end
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : gen_entry
      lrukv_entry #(
         .RANK_W(RANK_W)
      ) u_entry (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel       (sel_vec[g]),
         .touch_rank(touch_rank),
         .status    (status[g]),
         .rank      (rank[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         capacity_ff  <= capacity_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ sv/lrukv_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lrukv_pkg and lru_key_value_cache_defines.svh.
`include "lru_key_value_cache_defines.svh"

module lrukv_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input lrukv_pkg::req_payload_type  req_payload,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input lrukv_pkg::rsp_payload_type  rsp_payload
);
   import lrukv_pkg::*;

   // a stalled request holds
   `LRUKV_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_payload))

   // a stalled result holds
   `LRUKV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload))

   // an eviction only comes from a put miss
   `LRUKV_ASSERT_SAME(a_evict_put_miss, clock, reset, rsp_valid && rsp_payload.evicted,
      !rsp_payload.hit && (rsp_payload.read_value == '0))

   // no eviction, no evicted key
   `LRUKV_ASSERT_SAME(a_evict_key_zero, clock, reset, rsp_valid && !rsp_payload.evicted,
      rsp_payload.evicted_key == '0)

   // the cycle after reset shows an empty pipeline
   `LRUKV_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !req_stall && !rsp_valid)

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_payload(req_payload),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);
